FILE: hw/rtl/aapr_pkg.sv
// Package for the axis-angle point rotation pipeline.
// Holds widths, CORDIC constants and the arctangent table; no dependencies.
`timescale 1ns / 1ps
package aapr_pkg;
   localparam int CoordWidth    = 32;
   localparam int AxisWidth     = 16;
   localparam int AngleWidth    = 16;
   localparam int CordicWidth   = 36;
   localparam int AtanEntries   = 24;
   localparam int CORDIC_STEPS_DEFAULT    = 16;
   localparam int COORD_FRAC_BITS_DEFAULT = 16;
   localparam logic signed [CordicWidth-1:0] CordicGain = 36'sd652032874;
   localparam logic signed [CordicWidth-1:0] OneQ30     = 36'sd1073741824;

   typedef logic signed [CordicWidth-1:0] cordic_type;
   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [AxisWidth-1:0] axis_type;

   function automatic cordic_type atan_turn(input logic [4:0] idx);
      case (idx)
         5'd0: return 36'sd536870912;   5'd1: return 36'sd316933406;
         5'd2: return 36'sd167458907;   5'd3: return 36'sd85004756;
         5'd4: return 36'sd42667331;    5'd5: return 36'sd21354465;
         5'd6: return 36'sd10679838;    5'd7: return 36'sd5340245;
         5'd8: return 36'sd2670163;     5'd9: return 36'sd1335087;
         5'd10: return 36'sd667544;     5'd11: return 36'sd333772;
         5'd12: return 36'sd166886;     5'd13: return 36'sd83443;
         5'd14: return 36'sd41722;      5'd15: return 36'sd20861;
         5'd16: return 36'sd10430;      5'd17: return 36'sd5215;
         5'd18: return 36'sd2608;       5'd19: return 36'sd1304;
         5'd20: return 36'sd652;        5'd21: return 36'sd326;
         5'd22: return 36'sd163;        5'd23: return 36'sd81;
         default: return 36'sd0;
      endcase
   endfunction
endpackage

FILE: hw/rtl/axis_angle_point_rotation.sv
// Axis-angle (Rodrigues) point rotation about a line through a center.
//
// Input: a transaction is taken on a clock edge with start high and busy low.
// busy is always low: one transaction can enter every cycle.
// Output: rsp_valid marks each result for exactly one cycle; the receiver
// cannot stall, so no backpressure exists.
// Path: an input register, the CORDIC chain with each iteration registered,
// then five matrix stages. Throughput: one per cycle.
// Reset clears every valid bit; transactions in flight are dropped.
// The axis is used as given, not normalized. Outputs saturate to 32 bits.
// COORD_FRAC_BITS documents the coordinate format; outside 8 to 24 it blocks every transaction.
// Depends on aapr_pkg, aapr_sincos, aapr_matrix_apply.
`timescale 1ns / 1ps
module axis_angle_point_rotation #(
   parameter int CORDIC_STEPS    = aapr_pkg::CORDIC_STEPS_DEFAULT,
   parameter int COORD_FRAC_BITS = aapr_pkg::COORD_FRAC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  aapr_pkg::coord_type req_center_x,
   input  aapr_pkg::coord_type req_center_y,
   input  aapr_pkg::coord_type req_center_z,
   input  aapr_pkg::coord_type req_point_x,
   input  aapr_pkg::coord_type req_point_y,
   input  aapr_pkg::coord_type req_point_z,
   input  aapr_pkg::axis_type  req_axis_x,
   input  aapr_pkg::axis_type  req_axis_y,
   input  aapr_pkg::axis_type  req_axis_z,
   input  logic [aapr_pkg::AngleWidth-1:0] req_turn_angle,
   output logic rsp_valid,
   output aapr_pkg::coord_type rsp_rotated_x,
   output aapr_pkg::coord_type rsp_rotated_y,
   output aapr_pkg::coord_type rsp_rotated_z
);
   import aapr_pkg::*;
   localparam int Steps = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;
   localparam int Delay = Steps;
   localparam bit FracOk = (COORD_FRAC_BITS >= 8) && (COORD_FRAC_BITS <= 24);

   logic in_valid_ff;
   logic [AngleWidth-1:0] angle_ff;
   logic signed [32:0] d_ff [3];
   coord_type c_ff [3];
   axis_type  a_ff [3];
   logic signed [32:0] d_dly_ff [Delay+1][3];
   coord_type c_dly_ff [Delay+1][3];
   axis_type  a_dly_ff [Delay+1][3];
   logic sc_valid;
   cordic_type cos_w, sin_w;
   logic [2:0] outstanding_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else in_valid_ff <= start & ~busy & FracOk;
      angle_ff <= req_turn_angle;
      d_ff[0] <= 33'(req_point_x) - 33'(req_center_x);
      d_ff[1] <= 33'(req_point_y) - 33'(req_center_y);
      d_ff[2] <= 33'(req_point_z) - 33'(req_center_z);
      c_ff[0] <= req_center_x; c_ff[1] <= req_center_y; c_ff[2] <= req_center_z;
      a_ff[0] <= req_axis_x; a_ff[1] <= req_axis_y; a_ff[2] <= req_axis_z;
   end

   // side data rides alongside the CORDIC chain
   assign d_dly_ff[0] = d_ff;
   assign c_dly_ff[0] = c_ff;
   assign a_dly_ff[0] = a_ff;
   for (genvar k = 0; k < Delay; k++) begin : g_dly
      always_ff @(posedge clock) begin
         d_dly_ff[k+1] <= d_dly_ff[k];
         c_dly_ff[k+1] <= c_dly_ff[k];
         a_dly_ff[k+1] <= a_dly_ff[k];
      end
   end

   aapr_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sincos (
      .clock, .reset, .in_valid(in_valid_ff), .angle(angle_ff),
      .out_valid(sc_valid), .cos_q30(cos_w), .sin_q30(sin_w)
   );

   aapr_matrix_apply u_matrix (
      .clock, .reset, .in_valid(sc_valid), .cos_q30(cos_w), .sin_q30(sin_w),
      .ax(a_dly_ff[Steps][0]), .ay(a_dly_ff[Steps][1]), .az(a_dly_ff[Steps][2]),
      .dx(d_dly_ff[Steps][0]), .dy(d_dly_ff[Steps][1]), .dz(d_dly_ff[Steps][2]),
      .cx(c_dly_ff[Steps][0]), .cy(c_dly_ff[Steps][1]), .cz(c_dly_ff[Steps][2]),
      .out_valid(rsp_valid), .rx(rsp_rotated_x), .ry(rsp_rotated_y), .rz(rsp_rotated_z)
   );

   // small watch counter of valid items inside the matrix stages
   always_ff @(posedge clock) begin
      if (reset) outstanding_ff <= '0;
      else outstanding_ff <= outstanding_ff + 3'(sc_valid) - 3'(rsp_valid);
   end

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result right after reset");
   a_matrix_depth: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= 3'd5) else $error("matrix pipeline overfilled");
   a_result_traced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 3'd0) else $error("result without transaction");
endmodule

FILE: hw/rtl/aapr_cordic_stage.sv
// One rotation-mode CORDIC iteration with its pipeline register.
// Depends on aapr_pkg.
`timescale 1ns / 1ps
module aapr_cordic_stage #(
   parameter int STEP = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  aapr_pkg::cordic_type x_in_d,
   input  aapr_pkg::cordic_type y_in_d,
   input  aapr_pkg::cordic_type z_in_d,
   output logic               out_valid,
   output aapr_pkg::cordic_type x_out,
   output aapr_pkg::cordic_type y_out,
   output aapr_pkg::cordic_type z_out
);
   import aapr_pkg::*;
   cordic_type x_ff, y_ff, z_ff, x_in, y_in, z_in, xs, ys;
   logic valid_ff;

   always_comb begin
      xs = x_in_d >>> STEP;
      ys = y_in_d >>> STEP;
      if (!z_in_d[CordicWidth-1]) begin
         x_in = x_in_d - ys;
         y_in = y_in_d + xs;
         z_in = z_in_d - atan_turn(5'(STEP));
      end else begin
         x_in = x_in_d + ys;
         y_in = y_in_d - xs;
         z_in = z_in_d + atan_turn(5'(STEP));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= in_valid;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign out_valid = valid_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
endmodule

FILE: hw/rtl/aapr_sincos.sv
// Pipelined CORDIC sine/cosine: quadrant fold, iteration chain, unfold.
// Depends on aapr_pkg and aapr_cordic_stage.
`timescale 1ns / 1ps
module aapr_sincos #(
   parameter int CORDIC_STEPS = aapr_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [aapr_pkg::AngleWidth-1:0] angle,
   output logic                     out_valid,
   output aapr_pkg::cordic_type     cos_q30,
   output aapr_pkg::cordic_type     sin_q30
);
   import aapr_pkg::*;
   localparam int Steps = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;

   logic [AngleWidth-1:0] shifted;
   cordic_type x_w [Steps+1];
   cordic_type y_w [Steps+1];
   cordic_type z_w [Steps+1];
   logic       v_w [Steps+1];
   logic [1:0] quad_ff [Steps];
   logic [1:0] quad_in;

   always_comb begin
      shifted = angle + AngleWidth'(16'h2000);
      quad_in = shifted[15:14];
   end

   assign v_w[0] = in_valid;
   assign x_w[0] = CordicGain;
   assign y_w[0] = '0;
   assign z_w[0] = CordicWidth'($signed({1'b0, shifted[13:0]}) - 16'sh2000) <<< 16;

   always_ff @(posedge clock) quad_ff[0] <= quad_in;

   for (genvar i = 0; i < Steps; i++) begin : g_stage
      aapr_cordic_stage #(.STEP(i)) u_stage (
         .clock, .reset, .in_valid(v_w[i]),
         .x_in_d(x_w[i]), .y_in_d(y_w[i]), .z_in_d(z_w[i]),
         .out_valid(v_w[i+1]), .x_out(x_w[i+1]), .y_out(y_w[i+1]), .z_out(z_w[i+1])
      );
      if (i > 0) begin : g_q
         always_ff @(posedge clock) quad_ff[i] <= quad_ff[i-1];
      end
   end

   // quadrant tag is registered as often as the data (quad_ff[0] with stage 0), so index Steps-1
   logic [1:0] quad_out;
   assign quad_out = quad_ff[Steps-1];

   always_comb begin
      case (quad_out)
         2'd0: begin cos_q30 = x_w[Steps];  sin_q30 = y_w[Steps];  end
         2'd1: begin cos_q30 = -y_w[Steps]; sin_q30 = x_w[Steps];  end
         2'd2: begin cos_q30 = -x_w[Steps]; sin_q30 = -y_w[Steps]; end
         default: begin cos_q30 = y_w[Steps]; sin_q30 = -x_w[Steps]; end
      endcase
   end
   assign out_valid = v_w[Steps];
endmodule

FILE: hw/rtl/aapr_matrix_apply.sv
// Builds the rotation matrix and applies it to the offset vector over
// several register stages. Depends on aapr_pkg.
`timescale 1ns / 1ps
module aapr_matrix_apply (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  aapr_pkg::cordic_type cos_q30,
   input  aapr_pkg::cordic_type sin_q30,
   input  aapr_pkg::axis_type   ax,
   input  aapr_pkg::axis_type   ay,
   input  aapr_pkg::axis_type   az,
   input  logic signed [32:0]   dx,
   input  logic signed [32:0]   dy,
   input  logic signed [32:0]   dz,
   input  aapr_pkg::coord_type  cx,
   input  aapr_pkg::coord_type  cy,
   input  aapr_pkg::coord_type  cz,
   output logic                 out_valid,
   output aapr_pkg::coord_type  rx,
   output aapr_pkg::coord_type  ry,
   output aapr_pkg::coord_type  rz
);
   import aapr_pkg::*;
   typedef logic signed [31:0] prod_type;
   typedef logic signed [35:0] ent_type;
   typedef logic signed [69:0] acc_type;

   // stage A: axis products, t = 1 - cos
   logic     va_ff;
   prod_type pxx_ff, pyy_ff, pzz_ff, pxy_ff, pxz_ff, pyz_ff;
   cordic_type t_ff, c_ff, s_ff;
   axis_type ax_ff, ay_ff, az_ff;
   logic signed [32:0] da_ff [3];
   coord_type ca_ff [3];
   // stage B: matrix terms
   logic     vb_ff;
   ent_type  txx_ff, tyy_ff, tzz_ff, txy_ff, txz_ff, tyz_ff, sx_ff, sy_ff, sz_ff, c24_ff;
   logic signed [32:0] db_ff [3];
   coord_type cb_ff [3];
   // stage C: entries
   logic     vc_ff;
   ent_type  m_ff [9];
   logic signed [32:0] dc_ff [3];
   coord_type cc_ff [3];
   // stage D: products
   logic     vd_ff;
   acc_type  p_ff [9];
   coord_type cd_ff [3];
   // stage E: output
   logic     ve_ff;
   coord_type r_ff [3];

   function automatic ent_type rnd34(input cordic_type t, input prod_type p);
      logic signed [67:0] m;
      m = 68'(t) * 68'(p) + (68'sd1 <<< 33);
      return ent_type'(m >>> 34);
   endfunction
   function automatic ent_type rnd20(input cordic_type s, input axis_type a);
      logic signed [51:0] m;
      m = 52'(s) * 52'(a) + (52'sd1 <<< 19);
      return ent_type'(m >>> 20);
   endfunction
   function automatic coord_type fin(input acc_type a0, input acc_type a1,
                                     input acc_type a2, input coord_type c);
      acc_type s;
      logic signed [46:0] v;
      s = a0 + a1 + a2 + (70'sd1 <<< 23);
      v = 47'(s >>> 24) + 47'(c);
      if (v > 47'sd2147483647) return 32'sh7fffffff;
      if (v < -47'sd2147483648) return 32'sh80000000;
      return coord_type'(v);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0; vb_ff <= 1'b0; vc_ff <= 1'b0; vd_ff <= 1'b0; ve_ff <= 1'b0;
      end else begin
         va_ff <= in_valid; vb_ff <= va_ff; vc_ff <= vb_ff; vd_ff <= vc_ff; ve_ff <= vd_ff;
      end
      pxx_ff <= ax * ax; pyy_ff <= ay * ay; pzz_ff <= az * az;
      pxy_ff <= ax * ay; pxz_ff <= ax * az; pyz_ff <= ay * az;
      t_ff <= OneQ30 - cos_q30; c_ff <= cos_q30; s_ff <= sin_q30;
      ax_ff <= ax; ay_ff <= ay; az_ff <= az;
      da_ff[0] <= dx; da_ff[1] <= dy; da_ff[2] <= dz;
      ca_ff[0] <= cx; ca_ff[1] <= cy; ca_ff[2] <= cz;

      txx_ff <= rnd34(t_ff, pxx_ff); tyy_ff <= rnd34(t_ff, pyy_ff);
      tzz_ff <= rnd34(t_ff, pzz_ff); txy_ff <= rnd34(t_ff, pxy_ff);
      txz_ff <= rnd34(t_ff, pxz_ff); tyz_ff <= rnd34(t_ff, pyz_ff);
      sx_ff <= rnd20(s_ff, ax_ff); sy_ff <= rnd20(s_ff, ay_ff); sz_ff <= rnd20(s_ff, az_ff);
      c24_ff <= ent_type'((c_ff + 36'sd32) >>> 6);
      db_ff <= da_ff; cb_ff <= ca_ff;

      m_ff[0] <= c24_ff + txx_ff; m_ff[1] <= txy_ff - sz_ff; m_ff[2] <= txz_ff + sy_ff;
      m_ff[3] <= txy_ff + sz_ff; m_ff[4] <= c24_ff + tyy_ff; m_ff[5] <= tyz_ff - sx_ff;
      m_ff[6] <= txz_ff - sy_ff; m_ff[7] <= tyz_ff + sx_ff; m_ff[8] <= c24_ff + tzz_ff;
      dc_ff <= db_ff; cc_ff <= cb_ff;

      for (int i = 0; i < 9; i++) p_ff[i] <= acc_type'(m_ff[i]) * acc_type'(dc_ff[i % 3]);
      cd_ff <= cc_ff;

      for (int r = 0; r < 3; r++)
         r_ff[r] <= fin(p_ff[3*r], p_ff[3*r+1], p_ff[3*r+2], cd_ff[r]);
   end

   assign out_valid = ve_ff;
   assign rx = r_ff[0];
   assign ry = r_ff[1];
   assign rz = r_ff[2];
endmodule
